// ===== src/tekd_pkg.sv =====
// -----------------------------------------------------------------------------
// tekd_pkg
// Shared types, byte codes and the final-byte lookup table of the escape key
// decoder.
// -----------------------------------------------------------------------------
package tekd_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h1B;
   localparam logic [7:0] CSI_BYTE   = 8'h5B;  // '['
   localparam logic [7:0] SS3_BYTE   = 8'h4F;  // 'O'
   localparam logic [7:0] SEMI_BYTE  = 8'h3B;  // ';'
   localparam logic [7:0] TILDE_BYTE = 8'h7E;  // '~'
   localparam logic [7:0] TAB_BYTE   = 8'h09;

   localparam logic [7:0] MOD_SHIFT  = 8'h01;
   localparam logic [7:0] MOD_ALT    = 8'h02;

   localparam logic [7:0] N2_MAX     = 8'hFF;

   localparam logic [3:0] KC_CHAR  = 4'd0;
   localparam logic [3:0] KC_UP    = 4'd1;
   localparam logic [3:0] KC_DN    = 4'd2;
   localparam logic [3:0] KC_RT    = 4'd3;
   localparam logic [3:0] KC_LT    = 4'd4;
   localparam logic [3:0] KC_HOM   = 4'd5;
   localparam logic [3:0] KC_END   = 4'd6;
   localparam logic [3:0] KC_F1    = 4'd7;
   localparam logic [3:0] KC_F2    = 4'd8;
   localparam logic [3:0] KC_F3    = 4'd9;
   localparam logic [3:0] KC_F4    = 4'd10;
   localparam logic [3:0] KC_DEL   = 4'd11;
   localparam logic [3:0] KC_PGUP  = 4'd12;
   localparam logic [3:0] KC_PGDN  = 4'd13;

   typedef enum logic [1:0] {
      PH_START,   // awaiting first byte after escape
      PH_OPEN,    // after '[' or 'O'
      PH_N1,      // after the single-digit first number
      PH_N2       // inside the second number
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] mod_bits;
      logic [3:0] first_number;
      logic [7:0] second_number;
   } state_type;

   typedef struct packed {
      logic [7:0] modifiers;
      logic [7:0] char_value;
      logic [3:0] key_code;
   } result_type;

   typedef struct packed {
      logic [3:0] key_code;
      logic [7:0] char_value;
      logic [7:0] mod_extra;
   } lookup_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_START,
      mod_bits:      8'd0,
      first_number:  4'd1,
      second_number: 8'd0
   };

   // Final byte table; an unmatched byte gives character 0.
   function automatic lookup_type key_lookup(input logic [7:0] fin);
      lookup_type r;
      r = '{key_code: KC_CHAR, char_value: 8'd0, mod_extra: 8'd0};
      case (fin)
         8'h41:   r.key_code = KC_UP;       // 'A'
         8'h42:   r.key_code = KC_DN;       // 'B'
         8'h43:   r.key_code = KC_RT;       // 'C'
         8'h44:   r.key_code = KC_LT;       // 'D'
         8'h48:   r.key_code = KC_HOM;      // 'H'
         8'h46:   r.key_code = KC_END;      // 'F'
         8'h50:   r.key_code = KC_F1;       // 'P'
         8'h51:   r.key_code = KC_F2;       // 'Q'
         8'h52:   r.key_code = KC_F3;       // 'R'
         8'h53:   r.key_code = KC_F4;       // 'S'
         8'h5A: begin                       // 'Z': back-tab
            r.char_value = TAB_BYTE;
            r.mod_extra  = MOD_SHIFT;
         end
         8'h03:   r.key_code = KC_DEL;
         8'h05:   r.key_code = KC_PGUP;
         8'h06:   r.key_code = KC_PGDN;
         default: r.key_code = KC_CHAR;
      endcase
      return r;
   endfunction

endpackage

// ===== src/tekd_step.sv =====
// -----------------------------------------------------------------------------
// tekd_step
// Next-state and result logic for one received byte.
// -----------------------------------------------------------------------------
module tekd_step
   import tekd_pkg::*;
(
   input  state_type   cur_state,
   input  logic [7:0]  in_byte,
   output state_type   nxt_state,
   output logic        emit,
   output result_type  result
);

   logic        dec_digit;
   logic [11:0] n2_acc;
   logic [7:0]  n2_sat;
   logic [7:0]  fin_byte;
   logic [7:0]  fin_mods;
   lookup_type  hit;

   assign dec_digit = in_byte inside {[8'h30:8'h39]};

   // second_number * 10 + digit, then saturate
   assign n2_acc = ({4'd0, cur_state.second_number} << 3)
                 + ({4'd0, cur_state.second_number} << 1)
                 + {8'd0, in_byte[3:0]};
   assign n2_sat = (n2_acc > {4'd0, N2_MAX}) ? N2_MAX : n2_acc[7:0];

   assign fin_byte = (in_byte == TILDE_BYTE) ? {4'd0, cur_state.first_number} : in_byte;
   assign hit      = key_lookup(fin_byte);

   always_comb begin
      fin_mods = cur_state.mod_bits;
      if (cur_state.phase == PH_N2 && cur_state.second_number != 8'd0) begin
         fin_mods = cur_state.mod_bits | (cur_state.second_number - 8'd1);
      end
   end

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      result    = '{modifiers: fin_mods | hit.mod_extra,
                    char_value: hit.char_value,
                    key_code: hit.key_code};
      case (cur_state.phase)
         PH_START: begin
            if (in_byte == ESC_BYTE) begin
               nxt_state.mod_bits = cur_state.mod_bits | MOD_ALT;
            end else if (in_byte == CSI_BYTE || in_byte == SS3_BYTE) begin
               nxt_state.phase = PH_OPEN;
            end else begin
               emit   = 1'b1;
               result = '{modifiers: 8'd0,
                          char_value: (in_byte == 8'd0) ? ESC_BYTE : in_byte,
                          key_code: KC_CHAR};
            end
         end
         PH_OPEN, PH_N1: begin
            if (cur_state.phase == PH_OPEN && dec_digit) begin
               nxt_state.first_number = in_byte[3:0];
               nxt_state.phase        = PH_N1;
            end else if (in_byte == SEMI_BYTE) begin
               nxt_state.second_number = 8'd0;
               nxt_state.phase         = PH_N2;
            end else begin
               emit = 1'b1;
            end
         end
         PH_N2: begin
            if (dec_digit) begin
               nxt_state.second_number = n2_sat;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            nxt_state = STATE_RESET;
         end
      endcase
      if (emit) begin
         nxt_state = STATE_RESET;
      end
   end

endmodule

// ===== src/terminal_escape_key_decoder.sv =====
// -----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Decodes VT100/xterm escape sequences, one byte per word, into key words.
// -----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries the bytes that follow a leading escape, one per
//   word. The rsp_ channel carries one decoded key word each time a sequence
//   completes; bytes that only advance the sequence produce no word.
//   Path: an accepted byte lands in the input register, is decoded
//   combinationally and its key word is registered in the result register,
//   which drives rsp_.
//   Throughput: one byte per cycle unless rsp_ stalls (see Stall); the
//   decode is a single pass of short logic between the input register and
//   the result register, and the sequence state updates in that same pass.
//   Stall: while a key word waits on rsp_tready, a byte that produces no word
//   still advances; a byte that would produce a word holds in the input
//   register, and req_tready drops only once that register is full.
//   Reset: synchronous, active high; clears both valid flags and returns the
//   sequence state to "awaiting first byte", n1 = 1, n2 = 0, no modifiers.
// -----------------------------------------------------------------------------
module terminal_escape_key_decoder
   import tekd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata     // [3:0] key_code, [11:4] char_value,
                                     // [19:12] modifiers, [23:20] zero
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   state_type   step_state;
   logic        step_emit;
   result_type  step_result;
   logic        out_free;
   logic        advance;

   tekd_step u_step (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .nxt_state (step_state),
      .emit      (step_emit),
      .result    (step_result)
   );

   // Result register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;
   // Decode the held byte unless it produces a word with nowhere to go.
   assign advance  = in_valid_ff && (!step_emit || out_free);

   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   assign state_in = advance ? step_state : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = advance && step_emit;
         rsp_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff.modifiers, rsp_data_ff.char_value,
                        rsp_data_ff.key_code};

endmodule

// ===== tb/sv/terminal_escape_key_decoder_tb.sv =====
// -----------------------------------------------------------------------------
// terminal_escape_key_decoder_tb
// Self-checking bench for the escape key decoder. A short table of directed
// sequences runs first, followed by random escape sequences. Every accepted
// byte goes through an in-bench sequence decoder, and each key word on rsp_
// is compared with the oldest predicted key. Both channels idle and stall
// at random, with one stretch at full rate.
// -----------------------------------------------------------------------------
module terminal_escape_key_decoder_tb
   import tekd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_BYTES  = 950;
   localparam int DRAIN_CYCLES  = 8;
   localparam int IDLE_PERCENT  = 34;
   localparam int REPORT_LIMIT  = 10;
   localparam int STEADY_FIRST  = 400;   // accepted-byte window with no idling
   localparam int STEADY_LAST   = 600;

   localparam logic [7:0] DIGIT_0 = 8'h30;
   localparam logic [7:0] DIGIT_9 = 8'h39;
   localparam logic [7:0] CTRL_C  = 8'h03;   // raw final byte: delete
   localparam logic [7:0] CTRL_E  = 8'h05;   // raw final byte: page up
   localparam logic [7:0] CTRL_F  = 8'h06;   // raw final byte: page down

   // One byte of stimulus; fixed marks a row whose key word is typed in.
   typedef struct packed {
      logic [7:0] in_byte;
      bit         fixed;
      result_type want;
   } stim_row_type;

   localparam int N_ROWS = 24;

   // Directed sequences. Rows with fixed clear rely on the sequence decoder.
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // zero as the first byte decodes as a plain escape
      '{8'h00,      1'b1, '{8'd0, ESC_BYTE, KC_CHAR}},
      // top of the byte range as a plain key
      '{8'hFF,      1'b1, '{8'd0, 8'hFF, KC_CHAR}},
      // extra escape sets alt, but a plain key never carries modifiers
      '{ESC_BYTE,   1'b0, '0},
      '{"a",        1'b1, '{8'd0, "a", KC_CHAR}},
      // back-tab through SS3
      '{SS3_BYTE,   1'b0, '0},
      '{"Z",        1'b1, '{MOD_SHIFT, TAB_BYTE, KC_CHAR}},
      // tilde form of delete
      '{CSI_BYTE,   1'b0, '0},
      '{"3",        1'b0, '0},
      '{TILDE_BYTE, 1'b1, '{8'd0, 8'd0, KC_DEL}},
      // large n2 without n1 saturates
      '{CSI_BYTE,   1'b0, '0},
      '{SEMI_BYTE,  1'b0, '0},
      '{"9",        1'b0, '0},
      '{"9",        1'b0, '0},
      '{"9",        1'b0, '0},
      '{"D",        1'b0, '0},
      // n2 of zero adds nothing
      '{CSI_BYTE,   1'b0, '0},
      '{SEMI_BYTE,  1'b0, '0},
      '{"0",        1'b0, '0},
      '{"H",        1'b1, '{8'd0, 8'd0, KC_HOM}},
      // second digit after n1 is an unmatched final byte
      '{CSI_BYTE,   1'b0, '0},
      '{"2",        1'b0, '0},
      '{"3",        1'b1, '{8'd0, 8'd0, KC_CHAR}},
      // raw control byte as the final byte
      '{CSI_BYTE,   1'b0, '0},
      '{CTRL_E,     1'b1, '{8'd0, 8'd0, KC_PGUP}}
   };

   localparam int N_FINALS = 15;
   localparam logic [7:0] LIKELY_FINALS [N_FINALS] = '{
      "A", "B", "C", "D", "H", "F", "P", "Q", "R", "S", "Z",
      TILDE_BYTE, CTRL_C, CTRL_E, CTRL_F
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;    // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [3:0] key_code, [11:4] char_value,
                                      // [19:12] modifiers, [23:20] zero

   stim_row_type byte_stream [$];
   result_type   pending_keys [$];

   int drive_idx    = 0;
   int accept_idx   = 0;
   int error_count  = 0;
   int cycle_count  = 0;
   bit steady;

   // Sequence state of the in-bench decoder.
   phase_type  seq_phase;
   logic [7:0] seq_mods;
   logic [3:0] seq_n1;
   logic [7:0] seq_n2;

   terminal_escape_key_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // No idling on either side while this window of bytes goes through.
   assign steady = (accept_idx >= STEADY_FIRST) && (accept_idx < STEADY_LAST);

   // ---------------------------------------------------------------------------
   // Sequence decoder
   // ---------------------------------------------------------------------------
   function automatic void clear_sequence();
      seq_phase = PH_START;
      seq_mods  = 8'd0;
      seq_n1    = 4'd1;
      seq_n2    = 8'd0;
   endfunction

   function automatic bit is_dec_digit(input logic [7:0] b);
      return (b >= DIGIT_0) && (b <= DIGIT_9);
   endfunction

   // Map a final byte to a key; a tilde defers to n1.
   function automatic result_type final_key(input logic [7:0] b);
      logic [7:0] fin;
      result_type key;
      fin = (b == TILDE_BYTE) ? {4'd0, seq_n1} : b;
      key = '{modifiers: seq_mods, char_value: 8'd0, key_code: KC_CHAR};
      case (fin)
         "A":     key.key_code = KC_UP;
         "B":     key.key_code = KC_DN;
         "C":     key.key_code = KC_RT;
         "D":     key.key_code = KC_LT;
         "H":     key.key_code = KC_HOM;
         "F":     key.key_code = KC_END;
         "P":     key.key_code = KC_F1;
         "Q":     key.key_code = KC_F2;
         "R":     key.key_code = KC_F3;
         "S":     key.key_code = KC_F4;
         "Z": begin
            key.char_value = TAB_BYTE;
            key.modifiers  = seq_mods | MOD_SHIFT;
         end
         CTRL_C:  key.key_code = KC_DEL;
         CTRL_E:  key.key_code = KC_PGUP;
         CTRL_F:  key.key_code = KC_PGDN;
         default: key.key_code = KC_CHAR;
      endcase
      return key;
   endfunction

   // Advance the sequence by one byte; return 1 when it yields a key.
   function automatic bit decode_byte(input logic [7:0] b, output result_type key);
      bit          done;
      int unsigned acc;
      done = 1'b0;
      key  = '0;
      case (seq_phase)
         PH_START: begin
            if (b == ESC_BYTE) begin
               seq_mods = seq_mods | MOD_ALT;
            end else if (b == CSI_BYTE || b == SS3_BYTE) begin
               seq_phase = PH_OPEN;
            end else begin
               key.char_value = (b == 8'd0) ? ESC_BYTE : b;
               done = 1'b1;
            end
         end
         PH_OPEN, PH_N1: begin
            // after the opener a digit is n1; otherwise behave as after n1
            if (seq_phase == PH_OPEN && is_dec_digit(b)) begin
               seq_n1    = 4'(b - DIGIT_0);
               seq_phase = PH_N1;
            end else if (b == SEMI_BYTE) begin
               seq_n2    = 8'd0;
               seq_phase = PH_N2;
            end else begin
               key  = final_key(b);
               done = 1'b1;
            end
         end
         default: begin
            if (is_dec_digit(b)) begin
               acc    = int'(seq_n2) * 10 + int'(b - DIGIT_0);
               seq_n2 = (acc > 255) ? N2_MAX : 8'(acc);
            end else begin
               if (seq_n2 != 8'd0) seq_mods = seq_mods | (seq_n2 - 8'd1);
               key  = final_key(b);
               done = 1'b1;
            end
         end
      endcase
      if (done) clear_sequence();
      return done;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus build
   // ---------------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] b);
      byte_stream.push_back('{in_byte: b, fixed: 1'b0, want: '0});
   endfunction

   // Mostly well-formed sequences with random content; the rest is noise.
   function automatic void build_random_sequences();
      int n_digits;
      while (byte_stream.size() < N_ROWS + RANDOM_BYTES) begin
         // leading escapes set alt
         repeat ($urandom_range(0, 5) / 4) push_byte(ESC_BYTE);
         if ($urandom_range(0, 9) < 2) begin
            // plain key or noise: any byte at all
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            push_byte($urandom_range(0, 1) ? CSI_BYTE : SS3_BYTE);
            if ($urandom_range(0, 1)) push_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 2) != 0) begin
               push_byte(SEMI_BYTE);
               n_digits = $urandom_range(0, 4);
               repeat (n_digits) push_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
            end
            // usually a known final byte, sometimes a broken one
            if ($urandom_range(0, 9) < 8)
               push_byte(LIKELY_FINALS[$urandom_range(0, N_FINALS - 1)]);
            else
               push_byte(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Drive: present the next byte once the previous word went through
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (drive_idx < byte_stream.size() &&
             (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_stream[drive_idx].in_byte;
            drive_idx  <= drive_idx + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: predict on every accepted byte, check every accepted key word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type predicted;
      result_type seen;
      result_type oldest;
      bit         has_key;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            has_key = decode_byte(req_tdata, predicted);
            // typed-in rows stand on their own; the decoder still advances
            if (byte_stream[accept_idx].fixed)
               pending_keys.push_back(byte_stream[accept_idx].want);
            else if (has_key)
               pending_keys.push_back(predicted);
            accept_idx = accept_idx + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[19:0];
            if (pending_keys.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected key word %h at cycle %0d", rsp_tdata, cycle_count);
            end else begin
               oldest = pending_keys.pop_front();
               if (seen.key_code != oldest.key_code ||
                   seen.char_value != oldest.char_value ||
                   seen.modifiers != oldest.modifiers ||
                   rsp_tdata[23:20] != 4'd0) begin
                  error_count = error_count + 1;
                  if (error_count <= REPORT_LIMIT)
                     $display({"key word mismatch at cycle %0d: ",
                               "key %0d/%0d char %h/%h mods %h/%h pad %h"},
                              cycle_count, oldest.key_code, seen.key_code,
                              oldest.char_value, seen.char_value,
                              oldest.modifiers, seen.modifiers, rsp_tdata[23:20]);
               end
            end
         end
      end
   end

   // Watchdog on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------
   initial begin
      clear_sequence();
      for (int i = 0; i < N_ROWS; i++) byte_stream.push_back(DIRECTED_ROWS[i]);
      build_random_sequences();

      // hold reset, then release at an edge
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain: all bytes in, all keys out, then a last wait for strays
      while (accept_idx < byte_stream.size()) @(posedge clock);
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
